[rtl/core/nearest_point_to_line_core_assert.svh]
// Assertion macros for the nearest-point-to-line core.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef NEAREST_POINT_TO_LINE_CORE_ASSERT_SVH
`define NEAREST_POINT_TO_LINE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NPL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/npl_pkg.sv]
// Shared types and constants of the nearest-point-to-line core.
// Used by the controller, the datapath and the top level; no dependencies.
package npl_pkg;

  localparam int SCORE_BITS = 62;
  localparam int MUL_W      = 32;
  localparam int ADDR_W     = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_START_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_START_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_END_X   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_END_Y   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_END_Z   = 3'd5;

  typedef enum logic [3:0] {
    MUL_VY_DZ,
    MUL_VZ_DY,
    MUL_VZ_DX,
    MUL_VX_DZ,
    MUL_VX_DY,
    MUL_VY_DX,
    MUL_SQ_X,
    MUL_SQ_Y,
    MUL_SQ_Z
  } mul_sel_e;

  typedef enum logic [3:0] {
    ACC_NONE,
    ACC_CX_SET,
    ACC_CX_SUB,
    ACC_CY_SET,
    ACC_CY_SUB,
    ACC_CZ_SET,
    ACC_CZ_SUB,
    ACC_SC_SET,
    ACC_SC_ADD
  } acc_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CALC   = 3'b010,
    ST_FINISH = 3'b100
  } npl_state_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    acc_sel_e acc_sel;
    logic     update;
  } npl_cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } npl_status_t;

endpackage

[rtl/core/npl_ctrl.sv]
// Sequencer of the nearest-point-to-line core: steps the shared multiplier
// through six cross products and three squares per point. Depends on npl_pkg.
module npl_ctrl
  import npl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  npl_status_t status_i,
  output npl_cmd_t    cmd_o
);

  localparam logic [3:0] LAST_STEP = 4'd9;

  npl_state_e state_q, state_d;
  logic [3:0] step_q, step_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d        = state_q;
    step_d         = step_q;
    cmd_o.load     = 1'b0;
    cmd_o.mul_en   = 1'b0;
    cmd_o.mul_sel  = MUL_VY_DZ;
    cmd_o.acc_sel  = ACC_NONE;
    cmd_o.update   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = ST_CALC;
        end
      end
      ST_CALC: begin
        // The product of step n is folded into the sums at step n+1.
        cmd_o.mul_en = (step_q < LAST_STEP);
        unique case (step_q)
          4'd0: cmd_o.mul_sel = MUL_VY_DZ;
          4'd1: begin
            cmd_o.mul_sel = MUL_VZ_DY;
            cmd_o.acc_sel = ACC_CX_SET;
          end
          4'd2: begin
            cmd_o.mul_sel = MUL_VZ_DX;
            cmd_o.acc_sel = ACC_CX_SUB;
          end
          4'd3: begin
            cmd_o.mul_sel = MUL_VX_DZ;
            cmd_o.acc_sel = ACC_CY_SET;
          end
          4'd4: begin
            cmd_o.mul_sel = MUL_VX_DY;
            cmd_o.acc_sel = ACC_CY_SUB;
          end
          4'd5: begin
            cmd_o.mul_sel = MUL_VY_DX;
            cmd_o.acc_sel = ACC_CZ_SET;
          end
          4'd6: begin
            cmd_o.mul_sel = MUL_SQ_X;
            cmd_o.acc_sel = ACC_CZ_SUB;
          end
          4'd7: begin
            cmd_o.mul_sel = MUL_SQ_Y;
            cmd_o.acc_sel = ACC_SC_SET;
          end
          4'd8: begin
            cmd_o.mul_sel = MUL_SQ_Z;
            cmd_o.acc_sel = ACC_SC_ADD;
          end
          4'd9: cmd_o.acc_sel = ACC_SC_ADD;
          default: cmd_o.acc_sel = ACC_NONE;
        endcase
        if (step_q == LAST_STEP) begin
          state_d = ST_FINISH;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      ST_FINISH: begin
        // A closing point must not overwrite a result that is still waiting.
        if (!(status_i.last && status_i.out_busy)) begin
          cmd_o.update = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

[rtl/core/npl_datapath.sv]
// Datapath of the nearest-point-to-line core: offsets, one shared 32x32
// multiplier, cross-product and score sums, best-point store and result beat.
// Depends on npl_pkg and is driven by npl_ctrl.
module npl_datapath
  import npl_pkg::*;
#(
  parameter int COORD_BITS = 14
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  npl_cmd_t                     cmd_i,
  output npl_status_t                  status_o,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] start_z_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic signed [COORD_BITS-1:0] end_z_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] point_z_i,
  input  logic                         last_point_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic signed [COORD_BITS-1:0] nearest_x_o,
  output logic signed [COORD_BITS-1:0] nearest_y_o,
  output logic signed [COORD_BITS-1:0] nearest_z_o,
  output logic [SCORE_BITS-1:0]        best_score_o
);

  localparam int VW = COORD_BITS + 1;      // point or line offset
  localparam int XW = 2 * COORD_BITS + 3;  // cross-product component

  logic signed [COORD_BITS-1:0] px_q, py_q, pz_q;
  logic                         last_q;
  logic signed [VW-1:0]         vx_q, vy_q, vz_q;
  logic signed [VW-1:0]         dx, dy, dz;
  logic signed [MUL_W-1:0]      vx_e, vy_e, vz_e, dx_e, dy_e, dz_e;
  logic signed [MUL_W-1:0]      mul_a, mul_b;
  logic                         mul_sat;
  logic signed [2*MUL_W-1:0]    prod_q;
  logic                         prod_sat_q;
  logic signed [XW-1:0]         cx_q, cy_q, cz_q, csel;
  logic [XW-1:0]                mag;
  logic [2*MUL_W-1:0]           mag_e;
  logic [SCORE_BITS-1:0]        score_q, addend;
  logic [SCORE_BITS:0]          sum;
  logic [SCORE_BITS-1:0]        best_q;
  logic signed [COORD_BITS-1:0] bx_q, by_q, bz_q;
  logic                         have_best_q;
  logic                         take;
  logic [SCORE_BITS-1:0]        new_best;
  logic signed [COORD_BITS-1:0] new_bx, new_by, new_bz;
  logic                         out_valid_q;

  assign dx = {end_x_i[COORD_BITS-1], end_x_i} - {start_x_i[COORD_BITS-1], start_x_i};
  assign dy = {end_y_i[COORD_BITS-1], end_y_i} - {start_y_i[COORD_BITS-1], start_y_i};
  assign dz = {end_z_i[COORD_BITS-1], end_z_i} - {start_z_i[COORD_BITS-1], start_z_i};

  assign vx_e = {{(MUL_W-VW){vx_q[VW-1]}}, vx_q};
  assign vy_e = {{(MUL_W-VW){vy_q[VW-1]}}, vy_q};
  assign vz_e = {{(MUL_W-VW){vz_q[VW-1]}}, vz_q};
  assign dx_e = {{(MUL_W-VW){dx[VW-1]}}, dx};
  assign dy_e = {{(MUL_W-VW){dy[VW-1]}}, dy};
  assign dz_e = {{(MUL_W-VW){dz[VW-1]}}, dz};

  // Magnitude of the component being squared; at or above 2^31 the square
  // saturates the score.
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_SQ_Y: csel = cy_q;
      MUL_SQ_Z: csel = cz_q;
      default:  csel = cx_q;
    endcase
  end
  assign mag   = csel[XW-1] ? XW'(-csel) : XW'(csel);
  assign mag_e = (2*MUL_W)'(mag);

  always_comb begin
    mul_sat = 1'b0;
    unique case (cmd_i.mul_sel)
      MUL_VY_DZ: begin mul_a = vy_e; mul_b = dz_e; end
      MUL_VZ_DY: begin mul_a = vz_e; mul_b = dy_e; end
      MUL_VZ_DX: begin mul_a = vz_e; mul_b = dx_e; end
      MUL_VX_DZ: begin mul_a = vx_e; mul_b = dz_e; end
      MUL_VX_DY: begin mul_a = vx_e; mul_b = dy_e; end
      MUL_VY_DX: begin mul_a = vy_e; mul_b = dx_e; end
      MUL_SQ_X, MUL_SQ_Y, MUL_SQ_Z: begin
        mul_a   = {1'b0, mag_e[MUL_W-2:0]};
        mul_b   = {1'b0, mag_e[MUL_W-2:0]};
        mul_sat = |mag_e[2*MUL_W-1:MUL_W-1];
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign addend = prod_sat_q ? {SCORE_BITS{1'b1}} : prod_q[SCORE_BITS-1:0];
  assign sum    = {1'b0, score_q} + {1'b0, addend};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q   <= point_x_i;
      py_q   <= point_y_i;
      pz_q   <= point_z_i;
      last_q <= last_point_i;
      vx_q   <= {point_x_i[COORD_BITS-1], point_x_i} - {start_x_i[COORD_BITS-1], start_x_i};
      vy_q   <= {point_y_i[COORD_BITS-1], point_y_i} - {start_y_i[COORD_BITS-1], start_y_i};
      vz_q   <= {point_z_i[COORD_BITS-1], point_z_i} - {start_z_i[COORD_BITS-1], start_z_i};
    end
    if (cmd_i.mul_en) begin
      prod_q     <= mul_a * mul_b;
      prod_sat_q <= mul_sat;
    end
    unique case (cmd_i.acc_sel)
      ACC_CX_SET: cx_q <= prod_q[XW-1:0];
      ACC_CX_SUB: cx_q <= cx_q - prod_q[XW-1:0];
      ACC_CY_SET: cy_q <= prod_q[XW-1:0];
      ACC_CY_SUB: cy_q <= cy_q - prod_q[XW-1:0];
      ACC_CZ_SET: cz_q <= prod_q[XW-1:0];
      ACC_CZ_SUB: cz_q <= cz_q - prod_q[XW-1:0];
      ACC_SC_SET: score_q <= addend;
      ACC_SC_ADD: score_q <= sum[SCORE_BITS] ? {SCORE_BITS{1'b1}} : sum[SCORE_BITS-1:0];
      default: ;
    endcase
  end

  // The first point of a cloud always wins; later ones only on a strictly
  // smaller score.
  assign take     = !have_best_q || (score_q < best_q);
  assign new_best = take ? score_q : best_q;
  assign new_bx   = take ? px_q : bx_q;
  assign new_by   = take ? py_q : by_q;
  assign new_bz   = take ? pz_q : bz_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      best_q <= new_best;
      bx_q   <= new_bx;
      by_q   <= new_by;
      bz_q   <= new_bz;
      if (last_q) begin
        nearest_x_o  <= new_bx;
        nearest_y_o  <= new_by;
        nearest_z_o  <= new_bz;
        best_score_o <= new_best;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_best_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.update) begin
        have_best_q <= !last_q;
      end
      if (cmd_i.update && last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.last     = last_q;
  assign status_o.out_busy = out_valid_q && out_stall_i;

endmodule

[rtl/core/nearest_point_to_line_core.sv]
// A closing point's result beat is registered as the sequencer leaves its finish state.
// The core takes no new point until the last one is through, since the single shared 32x32 multiplier
// forms six cross products and three squares per point in turn.
// A pending result beat does not hold up the next point; only a closing point waits.
// Reset: line registers read zero, the search is cleared and no result is pending.
module nearest_point_to_line_core
  import npl_pkg::*;
#(
  parameter int COORD_BITS = 14
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_W-1:0]            paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] point_z_i,
  input  logic                         last_point_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] nearest_x_o,
  output logic signed [COORD_BITS-1:0] nearest_y_o,
  output logic signed [COORD_BITS-1:0] nearest_z_o,
  output logic [SCORE_BITS-1:0]        best_score_o
);

  logic signed [COORD_BITS-1:0] start_x_q, start_y_q, start_z_q;
  logic signed [COORD_BITS-1:0] end_x_q, end_y_q, end_z_q;
  logic signed [COORD_BITS-1:0] rd_val;
  logic [REG_IDX_W-1:0]         reg_idx;
  npl_cmd_t                     cmd;
  npl_status_t                  status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[REG_IDX_W+1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      start_z_q <= '0;
      end_x_q   <= '0;
      end_y_q   <= '0;
      end_z_q   <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_START_X: start_x_q <= pwdata[COORD_BITS-1:0];
        REG_START_Y: start_y_q <= pwdata[COORD_BITS-1:0];
        REG_START_Z: start_z_q <= pwdata[COORD_BITS-1:0];
        REG_END_X:   end_x_q   <= pwdata[COORD_BITS-1:0];
        REG_END_Y:   end_y_q   <= pwdata[COORD_BITS-1:0];
        REG_END_Z:   end_z_q   <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START_X: rd_val = start_x_q;
      REG_START_Y: rd_val = start_y_q;
      REG_START_Z: rd_val = start_z_q;
      REG_END_X:   rd_val = end_x_q;
      REG_END_Y:   rd_val = end_y_q;
      REG_END_Z:   rd_val = end_z_q;
      default:     rd_val = '0;
    endcase
  end
  assign prdata = {{(32-COORD_BITS){rd_val[COORD_BITS-1]}}, rd_val};

  npl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  npl_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .start_x_i    (start_x_q),
    .start_y_i    (start_y_q),
    .start_z_i    (start_z_q),
    .end_x_i      (end_x_q),
    .end_y_i      (end_y_q),
    .end_z_i      (end_z_q),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .last_point_i (last_point_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .nearest_x_o  (nearest_x_o),
    .nearest_y_o  (nearest_y_o),
    .nearest_z_o  (nearest_z_o),
    .best_score_o (best_score_o)
  );

`include "nearest_point_to_line_core_assert.svh"

  `NPL_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "idle after accept")
  `NPL_ASSERT_SAME(a_no_overwrite, cmd.update && status.last, !status.out_busy, "result overwritten")
  `NPL_ASSERT_SAME(a_result_src, $rose(out_valid_o), $past(cmd.update && status.last), "stray result")

endmodule

[tb/tb_nearest_point_to_line_core.sv]
// Self-checking testbench for nearest_point_to_line_core: a directed table, then random clouds.
// Needs npl_pkg and the core RTL; expected beats come from a predictor kept inside this file.
module tb_nearest_point_to_line_core
  import npl_pkg::*;
;

  localparam int COORD_BITS = 14;
  localparam int unsigned NUM_LINE_REGS = 6;
  localparam int unsigned TOTAL_POINTS = 1450;
  localparam int unsigned CALM_FROM = TOTAL_POINTS - 120;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam longint unsigned SCORE_CAP = (64'd1 << SCORE_BITS) - 1;

  // Register indexes that lie past the line registers; writes to them must be ignored.
  localparam logic [REG_IDX_W-1:0] REG_BEYOND_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_BEYOND_HI = 3'd7;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam coord_t COORD_MAX = ~COORD_MIN;

  typedef struct packed {
    coord_t                x;
    coord_t                y;
    coord_t                z;
    logic [SCORE_BITS-1:0] score;
  } nearest_t;

  typedef enum logic {ROW_WRITE, ROW_POINT} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [REG_IDX_W-1:0] idx;
    logic [31:0]          wdata;
    coord_t               x;
    coord_t               y;
    coord_t               z;
    logic                 last;
    bit                   typed;
    nearest_t             want;
  } plan_row_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  coord_t                point_x_i = '0;
  coord_t                point_y_i = '0;
  coord_t                point_z_i = '0;
  logic                  last_point_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  coord_t                nearest_x_o;
  coord_t                nearest_y_o;
  coord_t                nearest_z_o;
  logic [SCORE_BITS-1:0] best_score_o;

  nearest_point_to_line_core #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .point_z_i   (point_z_i),
    .last_point_i(last_point_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .nearest_x_o (nearest_x_o),
    .nearest_y_o (nearest_y_o),
    .nearest_z_o (nearest_z_o),
    .best_score_o(best_score_o)
  );

  // Predictor state: line registers and the running search.
  coord_t                line_reg [NUM_LINE_REGS] = '{default: '0};
  logic [SCORE_BITS-1:0] best_score_q = '1;
  coord_t                best_x = '0;
  coord_t                best_y = '0;
  coord_t                best_z = '0;
  bit                    have_best = 1'b0;

  nearest_t    expected_nearest [$];
  plan_row_t   directed_plan [$];
  int unsigned errors = 0;
  int unsigned points_sent = 0;
  bit          calm = 1'b0;
  bit          gaps_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned quiet_left = 0;
  nearest_t    seen_want;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_nearest_point_to_line_core NOT OK");
    $finish;
  end

  function automatic longint unsigned square_sat(input longint c);
    longint unsigned mag;
    mag = (c < 0) ? -c : c;
    if (mag >= (64'd1 << 31)) return SCORE_CAP;
    mag = mag * mag;
    return (mag > SCORE_CAP) ? SCORE_CAP : mag;
  endfunction

  // Scores one point against the current line and updates the search; returns 1 when the
  // point closes its cloud, with the winner in res.
  function automatic bit take_point(input coord_t px, input coord_t py, input coord_t pz,
                                    input logic last, output nearest_t res);
    longint dx, dy, dz, vx, vy, vz;
    longint unsigned sum;
    dx = longint'(line_reg[REG_END_X]) - longint'(line_reg[REG_START_X]);
    dy = longint'(line_reg[REG_END_Y]) - longint'(line_reg[REG_START_Y]);
    dz = longint'(line_reg[REG_END_Z]) - longint'(line_reg[REG_START_Z]);
    vx = longint'(px) - longint'(line_reg[REG_START_X]);
    vy = longint'(py) - longint'(line_reg[REG_START_Y]);
    vz = longint'(pz) - longint'(line_reg[REG_START_Z]);
    sum = square_sat(vy * dz - vz * dy);
    sum += square_sat(vz * dx - vx * dz);
    if (sum > SCORE_CAP) sum = SCORE_CAP;
    sum += square_sat(vx * dy - vy * dx);
    if (sum > SCORE_CAP) sum = SCORE_CAP;
    if (!have_best || sum < best_score_q) begin
      best_score_q = sum[SCORE_BITS-1:0];
      best_x = px;
      best_y = py;
      best_z = pz;
      have_best = 1'b1;
    end
    res = '{best_x, best_y, best_z, best_score_q};
    if (!last) return 1'b0;
    best_score_q = '1;
    best_x = '0;
    best_y = '0;
    best_z = '0;
    have_best = 1'b0;
    return 1'b1;
  endfunction

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '0;
      3: return coord_t'(int'($urandom_range(0, 64)) - 32);
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic void plan_write(input logic [REG_IDX_W-1:0] idx, input int val);
    plan_row_t r;
    r = '{kind: ROW_WRITE, idx: idx, wdata: 32'(val), default: '0};
    directed_plan = {directed_plan, r};
  endfunction

  function automatic void plan_point(input int x, input int y, input int z, input bit last);
    plan_row_t r;
    r = '{kind: ROW_POINT, x: coord_t'(x), y: coord_t'(y), z: coord_t'(z), last: last,
          default: '0};
    directed_plan = {directed_plan, r};
  endfunction

  // A closing point whose winner is plain to see, typed in directly.
  function automatic void plan_closing(input int x, input int y, input int z, input int ex,
                                       input int ey, input int ez, input longint es);
    plan_row_t r;
    r = '{kind: ROW_POINT, x: coord_t'(x), y: coord_t'(y), z: coord_t'(z), last: 1'b1,
          typed: 1'b1, want: '{coord_t'(ex), coord_t'(ey), coord_t'(ez), SCORE_BITS'(es)},
          default: '0};
    directed_plan = {directed_plan, r};
  endfunction

  // One APB write followed by a read of the same register, then psel is dropped.
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx < NUM_LINE_REGS) line_reg[idx] = coord_t'(data);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx < NUM_LINE_REGS && prdata[COORD_BITS-1:0] !== line_reg[idx]) begin
      $error("prdata: expected %0h, got %0h", line_reg[idx], prdata[COORD_BITS-1:0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Upper data bits are either a sign extension or noise; only the low bits count.
  task automatic write_coord(input logic [REG_IDX_W-1:0] idx, input coord_t v);
    logic [31:0] wdata;
    wdata = $urandom();
    wdata[COORD_BITS-1:0] = v;
    if ($urandom_range(0, 1) == 0) wdata = 32'(v);
    reg_write(idx, wdata);
  endtask

  task automatic send_point(input coord_t x, input coord_t y, input coord_t z, input logic last,
                            input bit typed, input nearest_t want);
    nearest_t res;
    in_valid_i   <= 1'b1;
    point_x_i    <= x;
    point_y_i    <= y;
    point_z_i    <= z;
    last_point_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    points_sent++;
    if (points_sent >= CALM_FROM) calm = 1'b1;
    if (take_point(x, y, z, last, res)) begin
      expected_nearest = {expected_nearest, typed ? want : res};
    end
    if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // Lets every expected beat arrive and the last open point finish before a register write.
  task automatic wait_for_quiet();
    in_valid_i <= 1'b0;
    while (expected_nearest.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || calm) begin
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (quiet_left != 0) begin
      quiet_left  <= quiet_left - 1;
      out_stall_i <= 1'b0;
    end else begin
      case ($urandom_range(0, 9))
        0, 1: begin
          stall_left  <= $urandom_range(0, 10);
          out_stall_i <= 1'b1;
        end
        2: begin
          quiet_left  <= $urandom_range(20, 60);
          out_stall_i <= 1'b0;
        end
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_nearest.size() == 0) begin
        $error("result beat with no point cloud closed");
        errors++;
      end else begin
        seen_want = expected_nearest.pop_front();
        if (nearest_x_o !== seen_want.x) begin
          $error("nearest_x: expected %0d, got %0d", seen_want.x, nearest_x_o);
          errors++;
        end
        if (nearest_y_o !== seen_want.y) begin
          $error("nearest_y: expected %0d, got %0d", seen_want.y, nearest_y_o);
          errors++;
        end
        if (nearest_z_o !== seen_want.z) begin
          $error("nearest_z: expected %0d, got %0d", seen_want.z, nearest_z_o);
          errors++;
        end
        if (best_score_o !== seen_want.score) begin
          $error("best_score: expected %0d, got %0d", seen_want.score, best_score_o);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    int       n_clouds;
    int       len;
    bit       cloud_open;
    coord_t   px, py, pz;
    coord_t   v;
    nearest_t no_want;

    no_want = '0;
    px = '0;
    py = '0;
    pz = '0;

    // Straight after reset the line collapses to a point, so the first point of a cloud wins.
    plan_point(8191, -8192, 8191, 1'b0);
    plan_closing(-8192, 8191, -8192, 8191, -8192, 8191, 0);
    plan_closing(0, 0, 0, 0, 0, 0, 0);
    // Line along x through the origin: the score is y squared plus z squared.
    plan_write(REG_END_X, 1);
    plan_closing(5, 3, 4, 5, 3, 4, 25);
    plan_point(7, 1, 0, 1'b0);
    plan_closing(-7, 0, 1, 7, 1, 0, 1);
    plan_closing(-8192, 8191, -8192, -8192, 8191, -8192, 134201345);
    plan_point(3, 9, 9, 1'b0);
    plan_point(0, 0, 0, 1'b0);
    plan_closing(1, 0, 0, 0, 0, 0, 0);
    // Line between far corners of the coordinate range.
    plan_write(REG_START_X, -8192);
    plan_write(REG_START_Y, -8192);
    plan_write(REG_START_Z, -8192);
    plan_write(REG_END_X, 8191);
    plan_write(REG_END_Y, 8191);
    plan_write(REG_END_Z, -8192);
    plan_point(8191, -8192, 8191, 1'b0);
    plan_point(-8192, 8191, 8191, 1'b0);
    plan_point(8191, 8191, -8192, 1'b1);
    // A line register rewritten in the middle of a cloud.
    plan_point(100, -200, 300, 1'b0);
    plan_write(REG_END_Y, -8192);
    plan_point(-100, 200, -300, 1'b0);
    plan_point(0, 0, 0, 1'b1);
    plan_write(REG_BEYOND_LO, 'h155);
    plan_write(REG_BEYOND_HI, -1);
    // End moved onto start: every score is zero.
    plan_write(REG_END_X, -8192);
    plan_point(42, -42, 8191, 1'b0);
    plan_closing(-1, -1, -1, 42, -42, 8191, 0);
    plan_write(REG_START_X, 8191);
    plan_write(REG_START_Y, -8192);
    plan_write(REG_START_Z, 8191);
    plan_write(REG_END_X, -8192);
    plan_write(REG_END_Y, 8191);
    plan_write(REG_END_Z, -8192);
    plan_point(-8192, 8191, 8191, 1'b0);
    plan_point(8191, 8191, -8192, 1'b0);
    plan_point(-8192, -8192, -8192, 1'b1);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_WRITE) begin
        wait_for_quiet();
        reg_write(directed_plan[i].idx, directed_plan[i].wdata);
      end else begin
        send_point(directed_plan[i].x, directed_plan[i].y, directed_plan[i].z,
                   directed_plan[i].last, directed_plan[i].typed, directed_plan[i].want);
      end
    end

    while (points_sent < TOTAL_POINTS) begin
      wait_for_quiet();
      case ($urandom_range(0, 3))
        0: begin
          for (int r = 0; r < NUM_LINE_REGS; r++) write_coord(REG_IDX_W'(r), pick_coord());
        end
        1: begin
          for (int r = 0; r < 3; r++) begin
            v = pick_coord();
            write_coord(REG_IDX_W'(REG_START_X + r), v);
            write_coord(REG_IDX_W'(REG_END_X + r), v);
          end
        end
        default: begin
          repeat ($urandom_range(1, 3)) begin
            write_coord(REG_IDX_W'($urandom_range(0, 7)), pick_coord());
          end
        end
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);

      n_clouds = $urandom_range(1, 5);
      for (int c = 0; c < n_clouds; c++) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(16, 48) : $urandom_range(1, 6);
        cloud_open = (c == n_clouds - 1) && ($urandom_range(0, 7) == 0);
        for (int j = 0; j < len; j++) begin
          case ($urandom_range(0, 9))
            0: begin
              px = line_reg[REG_START_X];
              py = line_reg[REG_START_Y];
              pz = line_reg[REG_START_Z];
            end
            1: begin
              px = line_reg[REG_END_X];
              py = line_reg[REG_END_Y];
              pz = line_reg[REG_END_Z];
            end
            2: ;  // repeat the previous point to provoke a tie
            default: begin
              px = pick_coord();
              py = pick_coord();
              pz = pick_coord();
            end
          endcase
          send_point(px, py, pz, (j == len - 1) && !cloud_open, 1'b0, no_want);
        end
      end
    end

    wait_for_quiet();
    if (errors == 0) begin
      $display("tb_nearest_point_to_line_core OK");
    end else begin
      $display("tb_nearest_point_to_line_core NOT OK");
    end
    $finish;
  end

endmodule
